@@ design/jit_pkg.sv @@
package jit_pkg;

  // Joint count and derived widths
  localparam int JOINTS    = 7;
  localparam int JOINT_W   = 3;
  localparam int JOINT_AW  = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  // Configuration port
  localparam int CFG_AW    = 6;
  localparam int PDATA_W   = 64;

  // Register reset values
  localparam logic [15:0] COR_SCALE_RST = 16'd256;
  localparam logic [30:0] STEP_RST      = 31'd65536;
  localparam logic [15:0] FW_RST        = 16'd64881;

  // Register map, one 8-byte slot per register
  typedef enum logic [2:0] {
    REG_K_LO,
    REG_K_HI,
    REG_D_LO,
    REG_D_HI,
    REG_COR_SCALE,
    REG_STEP,
    REG_FILTER_W
  } reg_idx_t;

  // One joint sample
  typedef struct packed {
    logic [JOINT_W-1:0] joint_index;
    logic signed [31:0] joint_position;
    logic signed [31:0] target_position;
    logic signed [31:0] joint_speed;
    logic signed [31:0] target_speed;
    logic signed [31:0] coriolis_torque;
    logic signed [31:0] last_torque;
  } in_item_t;

  // One torque command
  typedef struct packed {
    logic [JOINT_W-1:0] out_joint;
    logic signed [31:0] torque_command;
  } out_item_t;

endpackage

@@ design/jit_ram.sv @@
module jit_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read (old data on same-edge collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/joint_impedance_torque_law.sv @@
// Joint impedance torque law: each sample transfer on the input channel yields one
// torque command transfer, in order, for the joint named in the sample. The block
// takes one sample per clock cycle sustained while the output buffer has room; a
// sample moves through registered stages A, B, C, D and E into the output buffer.
// That rate is set by the velocity filter update, one
// multiply-add per cycle on the joint's filtered speed, which is read from a
// state RAM with separate read and write ports one stage ahead and written back in
// the next; a sample that
// follows one of the same joint gets the fresh value through a forwarding path. The
// filter state reads as zero after reset (per-joint valid bits, no clearing pass).
// A two-entry output buffer keeps the input open while one command waits. Write the
// configuration registers (8-byte slots on the APB port) only while no sample is in
// flight. A joint index outside the joint range passes last_torque through unchanged.
module joint_impedance_torque_law (
  input  logic                     clk,
  input  logic                     rst_n,
  // sample channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  jit_pkg::in_item_t        in_data,
  // command channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output jit_pkg::out_item_t       out_data,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [jit_pkg::CFG_AW-1:0]  paddr,
  input  logic [jit_pkg::PDATA_W-1:0] pwdata,
  output logic [jit_pkg::PDATA_W-1:0] prdata,
  output logic                     pready
);
  import jit_pkg::*;

  localparam logic [4:0] JOINTS_V  = 5'(JOINTS);
  localparam logic [1:0] SKID_FULL = 2'd2;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [63:0] k_lo_r, d_lo_r;
  logic [47:0] k_hi_r, d_hi_r;
  logic [15:0] cor_scale_r;
  logic [30:0] step_r;
  logic [15:0] fw_r;
  logic        cfg_we;
  reg_idx_t    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_lo_r      <= '0;
      k_hi_r      <= '0;
      d_lo_r      <= '0;
      d_hi_r      <= '0;
      cor_scale_r <= COR_SCALE_RST;
      step_r      <= STEP_RST;
      fw_r        <= FW_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_K_LO:      k_lo_r      <= pwdata;
        REG_K_HI:      k_hi_r      <= pwdata[47:0];
        REG_D_LO:      d_lo_r      <= pwdata;
        REG_D_HI:      d_hi_r      <= pwdata[47:0];
        REG_COR_SCALE: cor_scale_r <= pwdata[15:0];
        REG_STEP:      step_r      <= pwdata[30:0];
        REG_FILTER_W:  fw_r        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (cfg_idx)
      REG_K_LO:      prdata = k_lo_r;
      REG_K_HI:      prdata = {16'h0, k_hi_r};
      REG_D_LO:      prdata = d_lo_r;
      REG_D_HI:      prdata = {16'h0, d_hi_r};
      REG_COR_SCALE: prdata = {48'h0, cor_scale_r};
      REG_STEP:      prdata = {33'h0, step_r};
      REG_FILTER_W:  prdata = {48'h0, fw_r};
      default:       prdata = '0;
    endcase
  end

  // Packed 16-bit gain of a joint; joints without a slot read zero
  function automatic logic [15:0] gain_of(input logic [63:0] lo, input logic [47:0] hi,
                                          input logic [JOINT_W-1:0] j);
    logic [5:0]  sh;
    logic [15:0] g;
    sh = {j[1:0], 4'b0000};
    if (j < 3'd4) begin
      g = lo[sh +: 16];
    end else if (j < 3'd7) begin
      g = hi[sh +: 16];
    end else begin
      g = '0;
    end
    return g;
  endfunction

  // ---------------------------------------------------------------------------
  // Pipeline control: all stages move together while the output buffer has room
  // ---------------------------------------------------------------------------
  logic [1:0] cnt_r, cnt_nxt;
  logic       adv;

  assign adv      = (cnt_r != SKID_FULL);
  assign in_ready = adv;

  // ---------------------------------------------------------------------------
  // Stage A: captured sample, state RAM read issued
  // ---------------------------------------------------------------------------
  logic                a_valid_r;
  in_item_t            a_item_r;
  logic                a_ok;
  logic [JOINT_AW-1:0] a_addr;
  logic signed [48:0]  a_pw;
  logic signed [32:0]  a_pd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_item_r <= in_data;
    end
  end

  assign a_ok   = ({2'b00, a_item_r.joint_index} < JOINTS_V);
  assign a_addr = JOINT_AW'(a_item_r.joint_index);
  // new-sample part of the filter sum, and position error
  assign a_pw   = $signed({1'b0, fw_r}) * a_item_r.joint_speed;
  assign a_pd   = a_item_r.target_position - a_item_r.joint_position;

  // ---------------------------------------------------------------------------
  // Stage B: filter update (multiply-add on the old filtered speed)
  // ---------------------------------------------------------------------------
  logic                b_valid_r, b_ok_r;
  logic [JOINT_W-1:0]  b_joint_r;
  logic signed [48:0]  b_pw_r;
  logic signed [32:0]  b_pd_r;
  logic signed [31:0]  b_dqd_r, b_cor_r, b_last_r;
  logic [JOINT_AW-1:0] b_addr;
  logic [JOINTS-1:0]   vld_r;
  logic [31:0]         ram_rdata;
  logic                fwd;
  logic                ram_we;
  logic signed [31:0]  b_old;
  logic [16:0]         w_old;
  logic signed [49:0]  b_po;
  logic signed [50:0]  b_fsum;
  logic signed [34:0]  b_fround;
  logic signed [31:0]  b_filt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_ok_r    <= a_ok;
      b_joint_r <= a_item_r.joint_index;
      b_pw_r    <= a_pw;
      b_pd_r    <= a_pd;
      b_dqd_r   <= a_item_r.target_speed;
      b_cor_r   <= a_item_r.coriolis_torque;
      b_last_r  <= a_item_r.last_torque;
    end
  end

  assign b_addr = JOINT_AW'(b_joint_r);
  assign ram_we = adv && b_valid_r && b_ok_r;

  jit_ram #(.WIDTH(32), .DEPTH(JOINTS)) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (b_addr),
    .wdata (b_filt),
    .re    (adv),
    .raddr (a_addr),
    .rdata (ram_rdata)
  );

  // Valid bits: unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ram_we) begin
      vld_r[b_addr] <= 1'b1;
    end
  end

  // The sample one stage ahead wrote at the same edge our read was taken: forward it
  assign fwd   = c_valid_r && c_ok_r && b_ok_r && (c_joint_r == b_joint_r);
  assign b_old = fwd ? c_filt_r : (vld_r[b_addr] ? $signed(ram_rdata) : 32'sd0);

  assign w_old    = 17'h10000 - {1'b0, fw_r};
  assign b_po     = $signed({1'b0, w_old}) * b_old;
  assign b_fsum   = b_po + b_pw_r + 51'sd32768;
  assign b_fround = b_fsum[50:16];
  assign b_filt   = (b_fround[34:31] == 4'b0000 || b_fround[34:31] == 4'b1111) ?
                    b_fround[31:0] :
                    (b_fround[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

  // ---------------------------------------------------------------------------
  // Stage C: filtered speed registered, speed error, gain select
  // ---------------------------------------------------------------------------
  logic               c_valid_r, c_ok_r;
  logic [JOINT_W-1:0] c_joint_r;
  logic signed [31:0] c_filt_r, c_dqd_r, c_cor_r, c_last_r;
  logic signed [32:0] c_pd_r;
  logic signed [32:0] c_sd;
  logic [15:0]        c_k, c_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (adv) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_ok_r    <= b_ok_r;
      c_joint_r <= b_joint_r;
      c_filt_r  <= b_filt;
      c_pd_r    <= b_pd_r;
      c_dqd_r   <= b_dqd_r;
      c_cor_r   <= b_cor_r;
      c_last_r  <= b_last_r;
    end
  end

  assign c_sd = c_dqd_r - c_filt_r;
  assign c_k  = gain_of(k_lo_r, k_hi_r, c_joint_r);
  assign c_d  = gain_of(d_lo_r, d_hi_r, c_joint_r);

  // ---------------------------------------------------------------------------
  // Stage D: the three torque products
  // ---------------------------------------------------------------------------
  logic               d_valid_r, d_ok_r;
  logic [JOINT_W-1:0] d_joint_r;
  logic signed [48:0] d_pc_r;
  logic signed [49:0] d_pk_r, d_pdd_r;
  logic signed [31:0] d_last_r;
  logic signed [55:0] d_acc;
  logic signed [32:0] d_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (adv) begin
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_ok_r    <= c_ok_r;
      d_joint_r <= c_joint_r;
      d_pc_r    <= $signed({1'b0, cor_scale_r}) * c_cor_r;
      d_pk_r    <= $signed({1'b0, c_k}) * c_pd_r;
      d_pdd_r   <= $signed({1'b0, c_d}) * c_sd;
      d_last_r  <= c_last_r;
    end
  end

  // Sum in Q.24 with rounding offset, and rate-limit window around last torque
  assign d_acc  = d_pc_r + $signed({d_pk_r, 4'b0000}) + $signed({d_pdd_r, 4'b0000})
                  + 56'sd128;
  assign d_step = $signed({2'b00, step_r});

  // ---------------------------------------------------------------------------
  // Stage E: rounded torque and limit window
  // ---------------------------------------------------------------------------
  logic               e_valid_r, e_ok_r;
  logic [JOINT_W-1:0] e_joint_r;
  logic signed [47:0] e_tau_r;
  logic signed [32:0] e_hi_r, e_lo_r;
  logic signed [31:0] e_last_r;
  logic signed [47:0] e_clamp;
  logic signed [31:0] e_cmd;
  out_item_t          e_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (adv) begin
      e_valid_r <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_ok_r    <= d_ok_r;
      e_joint_r <= d_joint_r;
      e_tau_r   <= d_acc[55:8];
      e_hi_r    <= d_last_r + d_step;
      e_lo_r    <= d_last_r - d_step;
      e_last_r  <= d_last_r;
    end
  end

  // Clamp to the window, then saturate to Q16.16; an out-of-range joint keeps last torque
  always_comb begin
    if (e_tau_r > e_hi_r) begin
      e_clamp = 48'(e_hi_r);
    end else if (e_tau_r < e_lo_r) begin
      e_clamp = 48'(e_lo_r);
    end else begin
      e_clamp = e_tau_r;
    end
    if (!e_ok_r) begin
      e_cmd = e_last_r;
    end else if (e_clamp[47:31] == {17{e_clamp[47]}}) begin
      e_cmd = e_clamp[31:0];
    end else begin
      e_cmd = e_clamp[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    e_item.out_joint      = e_joint_r;
    e_item.torque_command = e_cmd;
  end

  // ---------------------------------------------------------------------------
  // Two-entry output buffer
  // ---------------------------------------------------------------------------
  out_item_t q0_r, q0_nxt, q1_r, q1_nxt;
  logic      push, pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = q0_r;
  assign pop       = out_valid && out_ready;
  assign push      = adv && e_valid_r;

  always_comb begin
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_r;
    case (cnt_r)
      2'd0: begin
        if (push) begin
          q0_nxt  = e_item;
          cnt_nxt = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          q0_nxt = e_item;
        end else if (push) begin
          q1_nxt  = e_item;
          cnt_nxt = 2'd2;
        end else if (pop) begin
          cnt_nxt = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          q0_nxt  = q1_r;
          cnt_nxt = 2'd1;
        end
      end
      default: cnt_nxt = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Back-to-back samples of one joint must take the forwarded filter value
  a_fwd_same_joint: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && a_valid_r && a_ok && b_valid_r && b_ok_r &&
     (a_item_r.joint_index == b_joint_r)) |=> fwd)
    else $error("forwarding missed for back-to-back joint");

  // A state write marks its entry valid
  a_vld_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> vld_r[$past(b_addr)])
    else $error("state entry not marked valid after write");

  // Output buffer never overfills
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 2'd3))
    else $error("output buffer count out of range");

  // No push into a full buffer
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == SKID_FULL) |=> (cnt_r != 2'd0 || $past(pop)))
    else $error("output buffer lost entries");

  // Reset clears the filter state valid bits
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (vld_r == '0))
    else $error("filter state not cleared by reset");

endmodule

@@ tb/sv/joint_impedance_torque_law_tb.sv @@
`timescale 1ns / 1ps

module joint_impedance_torque_law_tb;
  import jit_pkg::*;

  localparam logic [2:0]         REG_UNUSED = 3'd7;  // no register behind this slot
  localparam int                 QUIET_LIMIT = 2000;
  localparam int                 HOLD_CYCLES = 60;
  localparam int                 SETTLE_CYCLES = 10;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CFG_AW-1:0]   paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // Predictor copy of the registers and the per-joint filter state
  logic [63:0]         k_lo = '0;
  logic [47:0]         k_hi = '0;
  logic [63:0]         d_lo = '0;
  logic [47:0]         d_hi = '0;
  logic [15:0]         cor_scale = COR_SCALE_RST;
  logic [30:0]         step_max = STEP_RST;
  logic [15:0]         filt_weight = FW_RST;
  logic signed [31:0]  filt_speed [JOINTS];

  out_item_t           pending_torque [$];

  int in_gap_max = 0;
  int out_stall_max = 0;
  int ready_hold = 0;
  int next_joint = 0;
  int samples_sent = 0;
  int cmds_checked = 0;
  int clamp_count = 0;
  int oob_count = 0;
  int cfg_writes = 0;
  int fail_count = 0;
  int quiet_cycles = 0;

  joint_impedance_torque_law i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < JOINTS; i++) filt_speed[i] = '0;
  end

  function automatic longint clip32(longint x);
    if (x > longint'(Q_MAX)) return longint'(Q_MAX);
    if (x < longint'(Q_MIN)) return longint'(Q_MIN);
    return x;
  endfunction

  // Filter update, impedance torque, rate limit and saturation for one sample
  function automatic out_item_t predict_command(in_item_t s);
    out_item_t r;
    int        j;
    longint    w, old_v, spd, fsum, filt, k, d, cs, cor, q, qd, dqd;
    longint    acc, tau, diff, lim, last;
    j    = int'(s.joint_index);
    last = longint'(s.last_torque);
    r.out_joint      = s.joint_index;
    r.torque_command = s.last_torque;
    if (j >= JOINTS) begin
      oob_count++;
      return r;
    end
    w     = longint'(filt_weight);
    old_v = longint'(filt_speed[j]);
    spd   = longint'(s.joint_speed);
    fsum  = (65536 - w) * old_v + w * spd;
    filt  = clip32((fsum + 32768) >>> 16);
    filt_speed[j] = filt[31:0];
    if (j < 4) begin
      k = longint'(k_lo[j*16 +: 16]);
      d = longint'(d_lo[j*16 +: 16]);
    end else begin
      k = longint'(k_hi[(j-4)*16 +: 16]);
      d = longint'(d_hi[(j-4)*16 +: 16]);
    end
    cs  = longint'(cor_scale);
    cor = longint'(s.coriolis_torque);
    q   = longint'(s.joint_position);
    qd  = longint'(s.target_position);
    dqd = longint'(s.target_speed);
    // all three terms in Q.24, one rounding to Q16.16
    acc = cs * cor + k * (qd - q) * 16 + d * (dqd - filt) * 16;
    tau = (acc + 128) >>> 8;
    lim = longint'(step_max);
    diff = tau - last;
    if (diff > lim) begin
      diff = lim;
      clamp_count++;
    end else if (diff < -lim) begin
      diff = -lim;
      clamp_count++;
    end
    r.torque_command = 32'(clip32(last + diff));
    return r;
  endfunction

  function automatic in_item_t make_sample(logic [2:0] j, logic signed [31:0] q,
                                           logic signed [31:0] qd, logic signed [31:0] dq,
                                           logic signed [31:0] dqd, logic signed [31:0] cor,
                                           logic signed [31:0] last);
    in_item_t s;
    s.joint_index     = j;
    s.joint_position  = q;
    s.target_position = qd;
    s.joint_speed     = dq;
    s.target_speed    = dqd;
    s.coriolis_torque = cor;
    s.last_torque     = last;
    return s;
  endfunction

  // Mix of extremes, small values near zero and full-range values
  function automatic logic signed [31:0] pick_q16();
    case ($urandom_range(0, 9))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return '0;
      3, 4, 5: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(1, 64));
      default: return 16'($urandom());
    endcase
  endfunction

  // Send one sample; the predictor runs at the transfer edge
  task automatic send_sample(in_item_t s);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_torque = {pending_torque, predict_command(s)};
    samples_sent++;
  endtask

  task automatic send_random_sample();
    int j;
    case ($urandom_range(0, 7))
      0: j = $urandom_range(0, 7);   // noise, out-of-range joint included
      1: j = next_joint;             // same joint again, back to back
      default: begin
        next_joint = (next_joint + 1) % JOINTS;
        j = next_joint;
      end
    endcase
    send_sample(make_sample(3'(j), pick_q16(), pick_q16(), pick_q16(), pick_q16(),
                            pick_q16(), pick_q16()));
  endtask

  // Stop the input and wait until every command has come back
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_torque.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_K_LO:      k_lo = data;
      REG_K_HI:      k_hi = data[47:0];
      REG_D_LO:      d_lo = data;
      REG_D_HI:      d_hi = data[47:0];
      REG_COR_SCALE: cor_scale = data[15:0];
      REG_STEP:      step_max = data[30:0];
      REG_FILTER_W:  filt_weight = data[15:0];
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
  endtask

  // Random register set; junk in the unused upper bits must be dropped
  task automatic load_random_config();
    logic [63:0] junk;
    logic [15:0] scale, weight;
    logic [30:0] step;
    junk = {$urandom(), $urandom()};
    case ($urandom_range(0, 3))
      0: scale = 16'h0000;
      1: scale = 16'hFFFF;
      2: scale = COR_SCALE_RST;
      default: scale = 16'($urandom());
    endcase
    case ($urandom_range(0, 4))
      0: step = '0;
      1: step = 31'd1;
      2: step = 31'h7FFF_FFFF;
      3: step = 31'($urandom_range(0, 32'h0004_0000));
      default: step = 31'($urandom());
    endcase
    case ($urandom_range(0, 3))
      0: weight = 16'h0000;
      1: weight = 16'hFFFF;
      2: weight = FW_RST;
      default: weight = 16'($urandom());
    endcase
    cfg_write(REG_K_LO, {pick_gain(), pick_gain(), pick_gain(), pick_gain()});
    cfg_write(REG_K_HI, {junk[15:0], pick_gain(), pick_gain(), pick_gain()});
    cfg_write(REG_D_LO, {pick_gain(), pick_gain(), pick_gain(), pick_gain()});
    cfg_write(REG_D_HI, {junk[31:16], pick_gain(), pick_gain(), pick_gain()});
    cfg_write(REG_COR_SCALE, {junk[63:16], scale});
    cfg_write(REG_STEP, {junk[63:31], step});
    cfg_write(REG_FILTER_W, {junk[63:16], weight});
  endtask

  // Reset values: zero gains, unit Coriolis scale and unit step, empty filters
  task automatic test_reset_defaults();
    in_gap_max    = 2;
    out_stall_max = 2;
    send_sample(make_sample(0, '0, '0, '0, '0, Q_ONE, '0));
    send_sample(make_sample(1, '0, '0, '0, '0, Q_MAX, Q_MAX));
    send_sample(make_sample(2, '0, '0, '0, '0, Q_MIN, Q_MIN));
    send_sample(make_sample(3, '0, Q_ONE, Q_MAX, '0, 32'sh0000_8000, 32'sh0000_0001));
    send_sample(make_sample(3, '0, '0, Q_MIN, Q_MAX, 32'shFFFF_8000, '0));
    send_sample(make_sample(7, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MAX, 32'sh1234_5678));
  endtask

  // Largest gains, scale and step with extreme fields: saturation both ways
  task automatic test_gain_extremes();
    settle_block();
    cfg_write(REG_K_LO, '1);
    cfg_write(REG_K_HI, '1);
    cfg_write(REG_D_LO, '1);
    cfg_write(REG_D_HI, '1);
    cfg_write(REG_COR_SCALE, '1);
    cfg_write(REG_STEP, '1);
    cfg_write(REG_FILTER_W, '1);
    send_sample(make_sample(0, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
    send_sample(make_sample(4, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MIN));
    send_sample(make_sample(4, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN, '0));
    send_sample(make_sample(6, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MAX, '0));
    send_sample(make_sample(5, Q_ONE, Q_ONE, '0, '0, '0, 32'sh0000_0100));
  endtask

  // Filter weight zero holds the old speed, the largest weight takes nearly all of the new one;
  // back-to-back samples of one joint exercise the forwarding path
  task automatic test_filter_weights();
    settle_block();
    cfg_write(REG_K_LO, 64'h0010_0010_0010_0010);
    cfg_write(REG_D_HI, 64'h0000_0020_0020_0020);
    cfg_write(REG_STEP, 64'h0000_0000_7FFF_FFFF);
    cfg_write(REG_FILTER_W, 64'h0);
    in_gap_max    = 0;
    out_stall_max = 0;
    send_sample(make_sample(5, '0, '0, Q_MAX, '0, '0, '0));
    send_sample(make_sample(5, '0, '0, Q_MIN, Q_ONE, '0, '0));
    settle_block();
    cfg_write(REG_FILTER_W, 64'hFFFF);
    send_sample(make_sample(5, '0, '0, Q_MAX, '0, '0, '0));
    send_sample(make_sample(5, '0, '0, Q_MIN, '0, '0, '0));
    send_sample(make_sample(5, '0, '0, 32'sh0003_0000, Q_ONE, '0, '0));
    send_sample(make_sample(2, Q_ONE, '0, 32'shFFFF_0001, '0, '0, '0));
  endtask

  // Zero step holds the last torque; the unused register slot changes nothing
  task automatic test_zero_step();
    settle_block();
    cfg_write(REG_STEP, 64'hFFFF_FFFF_8000_0000);
    cfg_write(REG_UNUSED, '1);
    in_gap_max    = 3;
    out_stall_max = 3;
    send_sample(make_sample(1, Q_MIN, Q_MAX, '0, '0, Q_MAX, 32'sh0765_4321));
    send_sample(make_sample(6, Q_MAX, Q_MIN, '0, '0, Q_MIN, Q_MIN));
    send_sample(make_sample(0, '0, '0, '0, '0, '0, Q_MAX));
  endtask

  // Receiver holds off a long stretch while samples keep coming
  task automatic test_backpressure();
    settle_block();
    load_random_config();
    in_gap_max    = 0;
    out_stall_max = 0;
    ready_hold    = HOLD_CYCLES;
    repeat (40) send_random_sample();
  endtask

  task automatic test_random_phase(int count, int gap_max, int stall_max);
    settle_block();
    load_random_config();
    in_gap_max    = gap_max;
    out_stall_max = stall_max;
    repeat (count) send_random_sample();
  endtask

  // Receiver: random stalls per command, long hold-off on request
  initial begin : command_receiver
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (ready_hold > 0) begin
        stall = ready_hold;
        ready_hold = 0;
      end else begin
        stall = $urandom_range(0, out_stall_max);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Compare each command transfer with the oldest prediction
  always @(posedge clk) begin : command_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      cmds_checked++;
      if (pending_torque.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: unexpected command joint=%0d torque=%0d", $realtime,
                   out_data.out_joint, $signed(out_data.torque_command));
      end else begin
        want = pending_torque.pop_front();
        if (out_data.out_joint !== want.out_joint ||
            out_data.torque_command !== want.torque_command) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: mismatch joint exp=%0d act=%0d torque exp=%0d act=%0d",
                     $realtime, want.out_joint, out_data.out_joint,
                     $signed(want.torque_command), $signed(out_data.torque_command));
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d commands outstanding", $realtime,
                 quiet_cycles, pending_torque.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_gain_extremes();
    test_filter_weights();
    test_zero_step();
    test_backpressure();
    test_random_phase(360, 14, 14);
    test_random_phase(360, 0, 0);
    test_random_phase(360, 3, 14);
    test_random_phase(360, 14, 0);
    test_random_phase(360, 5, 5);
    settle_block();
    if (pending_torque.size() != 0) fail_count++;
    $display("Sent %0d joint samples, checked %0d torque commands (%0d rate-limited,",
             samples_sent, cmds_checked, clamp_count);
    $display("  %0d out-of-range joints) over %0d register writes.", oob_count, cfg_writes);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAIL");
    end
    $finish;
  end

endmodule
